[rtl/core/assert_macros.svh]
// Assertion macros shared by the kernel sum RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset gating and a caller-supplied message.
`define KSS_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check with the default message.
`define KSS_ASSERT(name, prop) \
  `KSS_ASSERT_MSG(name, prop, "kss check failed")

`endif

[rtl/core/kss_pkg.sv]
// Package: constants, types and helpers of the k-mer kernel sum.
package kss_pkg;

  localparam int unsigned MAX_LEN       = 32;
  localparam int unsigned ALPHABET_SIZE = 20;
  localparam int unsigned WEIGHT_BITS   = 24;

  localparam int unsigned FRAC_W    = WEIGHT_BITS - 2;
  localparam int unsigned OUT_FRAC  = 28;
  localparam int unsigned SCORE_W   = 63;
  localparam int unsigned KMER_W    = 6;
  localparam int unsigned RES_W     = 5;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W     = (LEN_W > KMER_W) ? LEN_W : KMER_W;
  localparam int unsigned TBL_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned ADDR_FW   = 2 * RES_W;
  localparam int unsigned HI_W      = SCORE_W - 32;
  localparam int unsigned HW_W      = HI_W + WEIGHT_BITS;
  localparam int unsigned LW_W      = 32 + WEIGHT_BITS;
  localparam int unsigned SH_W      = 32 - FRAC_W;
  localparam int unsigned CNT_W     = $clog2(MAX_LEN + 8);
  localparam int unsigned FLUSH_LEN = MAX_LEN + 4;
  localparam int unsigned PAIR_W    = 2 * (LEN_W + 1);

  localparam logic [SCORE_W-1:0] SAT_MAX = {SCORE_W{1'b1}};
  localparam logic [SCORE_W-1:0] ONE_Q   = SCORE_W'(1) << OUT_FRAC;

  localparam logic [FUNC_W-1:0] FUNC_TABLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIRST  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SECOND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KMER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KMER = 2'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [4:0]        row_index;
    logic [4:0]        col_index;
    logic [23:0]       table_value;
    logic [RES_W-1:0]  residue;
    logic              last_residue;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] kernel_score;
    logic               saturated;
  } out_t;

  // one diagonal element travelling down the cell row
  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       idx;
    logic [LEN_W-1:0]       n;
    logic [WEIGHT_BITS-1:0] weight;
  } item_t;

  typedef struct packed {
    logic [KMER_W-1:0] kmin;
    logic [KMER_W-1:0] kmax;
  } kcfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] acc;
    logic               flag;
  } stat_t;

  typedef struct packed {
    logic               ovf;
    logic [SCORE_W-1:0] val;
  } sum_t;

  // saturating add at 2^63-1
  function automatic sum_t sat_add(input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    sum_t             r;
    s     = {1'b0, a} + {1'b0, b};
    r.ovf = s[SCORE_W];
    r.val = s[SCORE_W] ? SAT_MAX : s[SCORE_W-1:0];
    return r;
  endfunction

endpackage

[rtl/core/kss_cell.sv]
// Cell: running product and partial sum for one start offset on a diagonal.
`include "assert_macros.svh"
module kss_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kss_pkg::IDX_W-1:0] cell_idx_i,
  input  kss_pkg::kcfg_t            kcfg_i,
  input  kss_pkg::item_t            item_i,
  output kss_pkg::item_t            item_o,
  input  logic                      drain_i,
  input  kss_pkg::stat_t            next_i,
  output kss_pkg::stat_t            stat_o
);
  import kss_pkg::*;

  item_t              item_q;
  logic               s1_v_q, s1_acc_q, s1_flg_q;
  logic [HW_W-1:0]    hw_q;
  logic [LW_W-1:0]    lw_q;
  logic               s2_v_q, s2_acc_q;
  logic [SCORE_W-1:0] prod_q, acc_q;
  logic               flag_q;

  logic               active, do_mul, acc_en, flg_en;
  logic [LEN_W-1:0]   step, avail;
  logic [SCORE_W-1:0] base, top, low_part, prod_d;
  logic [HW_W-1:0]    hw_d;
  logic [LW_W-1:0]    lw_d;
  logic               over, psat;
  sum_t               sum_m, acc_sum;

  always_comb begin
    active = item_i.valid && (item_i.idx >= cell_idx_i);
    step   = LEN_W'(item_i.idx - cell_idx_i) + LEN_W'(1);
    avail  = item_i.n - LEN_W'(cell_idx_i);
    do_mul = active && (CMP_W'(step) <= CMP_W'(kcfg_i.kmax));
    acc_en = CMP_W'(step) >= CMP_W'(kcfg_i.kmin);
    // product saturation counts only if the chain reaches the shortest k
    flg_en = (kcfg_i.kmin <= kcfg_i.kmax) && (CMP_W'(avail) >= CMP_W'(kcfg_i.kmin));
    base   = (item_i.idx == cell_idx_i) ? ONE_Q : prod_q;
    hw_d   = HW_W'(base[SCORE_W-1:32]) * HW_W'(item_i.weight);
    lw_d   = LW_W'(base[31:0]) * LW_W'(item_i.weight);
  end

  always_comb begin
    over     = |hw_q[HW_W-1:SCORE_W-SH_W];
    top      = {hw_q[SCORE_W-SH_W-1:0], {SH_W{1'b0}}};
    low_part = SCORE_W'(lw_q >> FRAC_W);
    sum_m    = sat_add(top, low_part);
    prod_d   = over ? SAT_MAX : sum_m.val;
    psat     = over | sum_m.ovf;
    acc_sum  = sat_add(acc_q, prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      acc_q  <= '0;
      flag_q <= 1'b0;
    end else begin
      item_q <= item_i;
      s1_v_q <= do_mul;
      s2_v_q <= s1_v_q;
      if (drain_i) begin
        acc_q  <= next_i.acc;
        flag_q <= next_i.flag;
      end else begin
        if (s2_v_q && s2_acc_q) acc_q <= acc_sum.val;
        flag_q <= flag_q | (s1_v_q & s1_flg_q & psat) | (s2_v_q & s2_acc_q & acc_sum.ovf);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hw_q     <= hw_d;
    lw_q     <= lw_d;
    s1_acc_q <= acc_en;
    s1_flg_q <= flg_en;
    s2_acc_q <= s1_acc_q;
    if (s1_v_q) prod_q <= prod_d;
  end

  assign item_o = item_q;
  assign stat_o = '{acc: acc_q, flag: flag_q};

  `KSS_ASSERT(a_drain_quiet, drain_i |-> (!s1_v_q && !s2_v_q && !item_q.valid))
  `KSS_ASSERT_MSG(a_item_spacing, item_i.valid |=> !item_i.valid, "items closer than the product loop")

endmodule

[rtl/core/kss_ctrl.sv]
// Controller: loads, table and sequence storage, diagonal sequencer, final sum.
`include "assert_macros.svh"
module kss_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  kss_pkg::in_t                  in_i,
  output logic                          done_o,
  output kss_pkg::out_t                 out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kss_pkg::KMER_W-1:0]    cfg_data_i,
  output kss_pkg::item_t                item_o,
  output kss_pkg::kcfg_t                kcfg_o,
  output logic                          drain_o,
  input  kss_pkg::stat_t                head_i
);
  import kss_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [KMER_W-1:0]      kmin_q, kmax_q;
  logic [RES_W-1:0]       seq1_q [MAX_LEN];
  logic [RES_W-1:0]       seq2_q [MAX_LEN];
  logic [WEIGHT_BITS-1:0] tbl_q  [TBL_DEPTH];
  logic [LEN_W-1:0]       len1_q, len2_q;
  logic                   dropped_q, closed_q, ovf_q;
  logic [IDX_W-1:0]       s1b_q, s2b_q, i_q;
  logic                   phase_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SCORE_W-1:0]     total_q;
  logic                   tsat_q;
  logic                   meta_v_q, zero_q;
  logic [IDX_W-1:0]       idx_q;
  logic [LEN_W-1:0]       n_q;
  logic [WEIGHT_BITS-1:0] rd_w_q;

  logic                   accept, issue, diag_end, last_issue, in_range, tbl_we;
  logic [IDX_W-1:0]       pos1, pos2;
  logic [RES_W-1:0]       r1, r2;
  logic [ADDR_FW-1:0]     raddr_f, waddr_f;
  logic [LEN_W-1:0]       rem1, rem2, n, eff1;
  logic [PAIR_W-1:0]      pairs;
  sum_t                   dsum;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign issue  = (state_q == ST_RUN) && !phase_q;

  always_comb begin
    pos1     = s1b_q + i_q;
    pos2     = s2b_q + i_q;
    r1       = seq1_q[pos1];
    r2       = seq2_q[pos2];
    in_range = (r1 < RES_W'(ALPHABET_SIZE)) && (r2 < RES_W'(ALPHABET_SIZE));
    raddr_f  = in_range ? (ADDR_FW'(r1) * ADDR_FW'(ALPHABET_SIZE) + ADDR_FW'(r2)) : '0;
    waddr_f  = ADDR_FW'(in_i.row_index) * ADDR_FW'(ALPHABET_SIZE) + ADDR_FW'(in_i.col_index);
    tbl_we   = accept && (in_i.func == FUNC_TABLE) &&
               (in_i.row_index < 5'(ALPHABET_SIZE)) && (in_i.col_index < 5'(ALPHABET_SIZE));
    rem1     = len1_q - LEN_W'(s1b_q);
    rem2     = len2_q - LEN_W'(s2b_q);
    n        = (rem1 < rem2) ? rem1 : rem2;
    diag_end   = (LEN_W'(i_q) + LEN_W'(1)) >= n;
    last_issue = diag_end && (s1b_q == '0) && ((LEN_W'(s2b_q) + LEN_W'(1)) >= len2_q);
    eff1     = closed_q ? '0 : len1_q;
    pairs    = PAIR_W'(len1_q + LEN_W'(1)) * PAIR_W'(len2_q + LEN_W'(1));
    dsum     = sat_add(total_q, head_i.acc);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && (in_i.func == FUNC_SECOND) && in_i.last_residue) state_d = ST_PREP;
      ST_PREP:  state_d = ((len1_q == '0) || (len2_q == '0)) ? ST_FLUSH : ST_RUN;
      ST_RUN:   if (issue && last_issue) state_d = ST_FLUSH;
      ST_FLUSH: if (cnt_q == CNT_W'(FLUSH_LEN - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (cnt_q == CNT_W'(MAX_LEN - 1)) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kmin_q    <= KMER_W'(1);
      kmax_q    <= KMER_W'(30);
      len1_q    <= '0;
      len2_q    <= '0;
      dropped_q <= 1'b0;
      closed_q  <= 1'b0;
      ovf_q     <= 1'b0;
      s1b_q     <= '0;
      s2b_q     <= '0;
      i_q       <= '0;
      phase_q   <= 1'b0;
      cnt_q     <= '0;
      total_q   <= '0;
      tsat_q    <= 1'b0;
      meta_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
      meta_v_q <= issue;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_KMER: kmin_q <= cfg_data_i;
          CFG_MAX_KMER: kmax_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (accept && (in_i.func == FUNC_FIRST)) begin
        closed_q <= in_i.last_residue;
        if (eff1 < LEN_W'(MAX_LEN)) begin
          len1_q    <= eff1 + LEN_W'(1);
          dropped_q <= closed_q ? 1'b0 : dropped_q;
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (accept && (in_i.func == FUNC_SECOND)) begin
        if (len2_q < LEN_W'(MAX_LEN)) len2_q <= len2_q + LEN_W'(1);
        else ovf_q <= 1'b1;
      end
      case (state_q)
        ST_PREP: begin
          // k = 0 contributes one empty product per start pair
          total_q <= (kmin_q == '0) ? (SCORE_W'(pairs) << OUT_FRAC) : '0;
          tsat_q  <= 1'b0;
          s1b_q   <= IDX_W'(len1_q - LEN_W'(1));
          s2b_q   <= '0;
          i_q     <= '0;
          phase_q <= 1'b0;
        end
        ST_RUN: begin
          phase_q <= !phase_q;
          if (issue) begin
            if (!diag_end) begin
              i_q <= i_q + IDX_W'(1);
            end else begin
              i_q <= '0;
              if (s1b_q != '0) s1b_q <= s1b_q - IDX_W'(1);
              else s2b_q <= s2b_q + IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          total_q <= dsum.val;
          tsat_q  <= tsat_q | dsum.ovf | head_i.flag;
        end
        ST_DONE: begin
          len2_q <= '0;
          ovf_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_q[waddr_f[TBL_AW-1:0]] <= WEIGHT_BITS'(in_i.table_value);
    if (accept && (in_i.func == FUNC_FIRST) && (eff1 < LEN_W'(MAX_LEN)))
      seq1_q[eff1[IDX_W-1:0]] <= in_i.residue;
    if (accept && (in_i.func == FUNC_SECOND) && (len2_q < LEN_W'(MAX_LEN)))
      seq2_q[len2_q[IDX_W-1:0]] <= in_i.residue;
    if (issue) begin
      rd_w_q <= tbl_q[raddr_f[TBL_AW-1:0]];
      idx_q  <= i_q;
      n_q    <= n;
      zero_q <= !in_range;
    end
  end

  assign item_o = '{valid: meta_v_q, idx: idx_q, n: n_q, weight: zero_q ? '0 : rd_w_q};
  assign kcfg_o = '{kmin: kmin_q, kmax: kmax_q};
  assign drain_o = (state_q == ST_DRAIN);
  assign done_o  = (state_q == ST_DONE);
  assign cfg_ready_o = 1'b1;
  assign out_o = '{kernel_score: total_q, saturated: tsat_q | ovf_q | dropped_q};

  `KSS_ASSERT(a_done_then_idle, done_o |=> !busy)
  `KSS_ASSERT(a_score_starts, (accept && (in_i.func == FUNC_SECOND) && in_i.last_residue) |=> busy)
  `KSS_ASSERT_MSG(a_issue_in_diag, issue |-> (LEN_W'(i_q) < n), "issue past diagonal end")

endmodule

[rtl/core/kmer_substitution_kernel_sum.sv]
// Top level: k-mer substitution kernel sum, controller plus a row of product cells.
// Loads (table word, residue) are taken only while idle; the receiver cannot stall results.
// The score strobe follows the last residue, and busy holds input off until then.
// Diagonal elements are spaced apart by the controller's phase toggle, which gives
// each cell's split-multiply product loop time to finish before the next element.
// Reset clears lengths, drop flags and cell sums and sets min_kmer 1, max_kmer 30.
module kmer_substitution_kernel_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  kss_pkg::in_t                  in_i,
  output logic                          done_o,
  output kss_pkg::out_t                 out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kss_pkg::KMER_W-1:0]    cfg_data_i
);
  import kss_pkg::*;

  item_t items [MAX_LEN+1];
  stat_t stats [MAX_LEN+1];
  kcfg_t kcfg;
  logic  drain;

  kss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_o      (items[0]),
    .kcfg_o      (kcfg),
    .drain_o     (drain),
    .head_i      (stats[0])
  );

  assign stats[MAX_LEN] = '0;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    kss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .kcfg_i     (kcfg),
      .item_i     (items[g]),
      .item_o     (items[g+1]),
      .drain_i    (drain),
      .next_i     (stats[g+1]),
      .stat_o     (stats[g])
    );
  end

endmodule
